// ----- design/pih_pkg.sv -----
// Shared types, codes and the face vertex table for the point-in-hexahedron block.
// No dependencies.
package pih_pkg;

	localparam int NUM_CORNERS = 8;
	localparam int FACE_LAST   = 5;
	localparam int STEP_LAST   = 18;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_V0,
		CAP_V1,
		CAP_V2,
		CAP_V3
	} cap_t;

	typedef enum logic [3:0] {
		MS_AY_BZ,
		MS_AZ_BY,
		MS_AZ_BX,
		MS_AX_BZ,
		MS_AX_BY,
		MS_AY_BX,
		MS_XL,
		MS_XH,
		MS_YL,
		MS_YH,
		MS_ZL,
		MS_ZH
	} msel_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_NX_SET,
		ACT_NX_SUB,
		ACT_NY_SET,
		ACT_NY_SUB,
		ACT_NZ_SET,
		ACT_NZ_SUB,
		ACT_ACC_SET,
		ACT_ACC_LO,
		ACT_ACC_HI
	} act_t;

	typedef struct packed {
		logic        wr_en;
		logic        ld_query;
		logic        rd_en;
		logic [2:0]  rd_addr;
		cap_t        cap;
		msel_t       msel;
		act_t        act;
		logic        chk;
	} cmd_t;

	function automatic logic [2:0] face_vtx(input logic [2:0] face, input logic [1:0] k);
		logic [11:0] row;
		begin
			case (face)
				3'd0: row = {3'd5, 3'd6, 3'd2, 3'd1};
				3'd1: row = {3'd3, 3'd7, 3'd4, 3'd0};
				3'd2: row = {3'd6, 3'd7, 3'd3, 3'd2};
				3'd3: row = {3'd4, 3'd5, 3'd1, 3'd0};
				3'd4: row = {3'd7, 3'd6, 3'd5, 3'd4};
				3'd5: row = {3'd1, 3'd2, 3'd3, 3'd0};
				default: row = '0;
			endcase
			face_vtx = row[3*k +: 3];
		end
	endfunction

endpackage

// ----- design/pih_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pih_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ----- design/pih_ctrl.sv -----
// Sequencer for the face tests: handshakes, face and step counters, datapath commands.
// Depends on pih_pkg.
module pih_ctrl import pih_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);
	state_t     state_q;
	logic [2:0] face_q;
	logic [4:0] step_q;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			face_q  <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && op) begin
						state_q <= ST_RUN;
						face_q  <= '0;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == 5'(STEP_LAST)) begin
						step_q <= '0;
						if (face_q == 3'(FACE_LAST)) begin
							state_q <= ST_DONE;
						end else begin
							face_q <= face_q + 3'd1;
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.cap      = CAP_NONE;
		cmd.msel     = MS_AY_BZ;
		cmd.act      = ACT_NONE;
		cmd.wr_en    = accept && !op;
		cmd.ld_query = accept && op;
		cmd.rd_addr  = face_vtx(face_q, step_q[1:0]);
		if (state_q == ST_RUN) begin
			cmd.rd_en = (step_q < 5'd4);
			case (step_q)
				5'd1:  cmd.cap = CAP_V0;
				5'd2:  cmd.cap = CAP_V1;
				5'd3:  cmd.cap = CAP_V2;
				5'd4:  cmd.cap = CAP_V3;
				default: cmd.cap = CAP_NONE;
			endcase
			case (step_q)
				5'd4:  cmd.msel = MS_AY_BZ;
				5'd5:  cmd.msel = MS_AZ_BY;
				5'd6:  cmd.msel = MS_AZ_BX;
				5'd7:  cmd.msel = MS_AX_BZ;
				5'd8:  cmd.msel = MS_AX_BY;
				5'd9:  cmd.msel = MS_AY_BX;
				5'd11: cmd.msel = MS_XL;
				5'd12: cmd.msel = MS_XH;
				5'd13: cmd.msel = MS_YL;
				5'd14: cmd.msel = MS_YH;
				5'd15: cmd.msel = MS_ZL;
				5'd16: cmd.msel = MS_ZH;
				default: cmd.msel = MS_AY_BZ;
			endcase
			case (step_q)
				5'd5:  cmd.act = ACT_NX_SET;
				5'd6:  cmd.act = ACT_NX_SUB;
				5'd7:  cmd.act = ACT_NY_SET;
				5'd8:  cmd.act = ACT_NY_SUB;
				5'd9:  cmd.act = ACT_NZ_SET;
				5'd10: cmd.act = ACT_NZ_SUB;
				5'd12: cmd.act = ACT_ACC_SET;
				5'd13: cmd.act = ACT_ACC_HI;
				5'd14: cmd.act = ACT_ACC_LO;
				5'd15: cmd.act = ACT_ACC_HI;
				5'd16: cmd.act = ACT_ACC_LO;
				5'd17: cmd.act = ACT_ACC_HI;
				default: cmd.act = ACT_NONE;
			endcase
			cmd.chk = (step_q == 5'(STEP_LAST));
		end
	end
endmodule

// ----- design/pih_dp.sv -----
// Datapath: corner store, edge vectors, face sums, shared multiplier, normal and dot accumulators.
// Depends on pih_pkg and pih_ram.
module pih_dp import pih_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  logic [2:0]                   vertex_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	output logic                         inside_res
);
	localparam int V = COORD_BITS;
	localparam int D = V + 1;
	localparam int S = V + 4;
	localparam int N = 2 * V + 3;
	localparam int K = V + 2;
	localparam int M = V + 4;
	localparam int P = 2 * M;
	localparam int A = 3 * V + 8;

	logic [NUM_CORNERS-1:0] vld_q;
	logic                   rd_vld_s1;
	logic [3*V-1:0]         rd_data;
	logic signed [V-1:0]    vd [3];
	logic signed [V-1:0]    v0_q [3];
	logic signed [V-1:0]    pt_q [3];
	logic signed [D-1:0]    a_q [3];
	logic signed [D-1:0]    b_q [3];
	logic signed [S-1:0]    sum_q [3];
	logic signed [N-1:0]    n_q [3];
	logic signed [A-1:0]    acc_q;
	logic signed [P-1:0]    p_q;
	logic signed [P-1:0]    prod;
	logic signed [A-1:0]    pe;
	logic signed [M-1:0]    op_a;
	logic signed [M-1:0]    op_b;
	logic                   inside_q;

	pih_ram #(.WIDTH(3 * V), .DEPTH(NUM_CORNERS)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (vertex_index),
		.wr_data ({coord_z, coord_y, coord_x}),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			inside_q  <= 1'b1;
		end else begin
			if (cmd.wr_en) begin
				vld_q[vertex_index] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_s1 <= vld_q[cmd.rd_addr];
			end
			if (cmd.ld_query) begin
				inside_q <= 1'b1;
			end else if (cmd.chk && acc_q[A-1]) begin
				inside_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vd[i] = rd_vld_s1 ? rd_data[i*V +: V] : '0;
		end
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.msel)
			MS_AY_BZ: begin
				op_a = {{(M-D){a_q[1][D-1]}}, a_q[1]};
				op_b = {{(M-D){b_q[2][D-1]}}, b_q[2]};
			end
			MS_AZ_BY: begin
				op_a = {{(M-D){a_q[2][D-1]}}, a_q[2]};
				op_b = {{(M-D){b_q[1][D-1]}}, b_q[1]};
			end
			MS_AZ_BX: begin
				op_a = {{(M-D){a_q[2][D-1]}}, a_q[2]};
				op_b = {{(M-D){b_q[0][D-1]}}, b_q[0]};
			end
			MS_AX_BZ: begin
				op_a = {{(M-D){a_q[0][D-1]}}, a_q[0]};
				op_b = {{(M-D){b_q[2][D-1]}}, b_q[2]};
			end
			MS_AX_BY: begin
				op_a = {{(M-D){a_q[0][D-1]}}, a_q[0]};
				op_b = {{(M-D){b_q[1][D-1]}}, b_q[1]};
			end
			MS_AY_BX: begin
				op_a = {{(M-D){a_q[1][D-1]}}, a_q[1]};
				op_b = {{(M-D){b_q[0][D-1]}}, b_q[0]};
			end
			MS_XL: begin
				op_a = sum_q[0];
				op_b = {{(M-K){1'b0}}, n_q[0][K-1:0]};
			end
			MS_XH: begin
				op_a = sum_q[0];
				op_b = {{(M-(N-K)){n_q[0][N-1]}}, n_q[0][N-1:K]};
			end
			MS_YL: begin
				op_a = sum_q[1];
				op_b = {{(M-K){1'b0}}, n_q[1][K-1:0]};
			end
			MS_YH: begin
				op_a = sum_q[1];
				op_b = {{(M-(N-K)){n_q[1][N-1]}}, n_q[1][N-1:K]};
			end
			MS_ZL: begin
				op_a = sum_q[2];
				op_b = {{(M-K){1'b0}}, n_q[2][K-1:0]};
			end
			MS_ZH: begin
				op_a = sum_q[2];
				op_b = {{(M-(N-K)){n_q[2][N-1]}}, n_q[2][N-1:K]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;
	assign pe   = {{(A-P){p_q[P-1]}}, p_q};

	always_ff @(posedge clk) begin
		p_q <= prod;
		if (cmd.ld_query) begin
			pt_q[0] <= coord_x;
			pt_q[1] <= coord_y;
			pt_q[2] <= coord_z;
		end
		for (int i = 0; i < 3; i++) begin
			case (cmd.cap)
				CAP_V0: begin
					v0_q[i]  <= vd[i];
					sum_q[i] <= {{(S-V){vd[i][V-1]}}, vd[i]};
				end
				CAP_V1: begin
					a_q[i]   <= {vd[i][V-1], vd[i]} - {v0_q[i][V-1], v0_q[i]};
					sum_q[i] <= sum_q[i] + {{(S-V){vd[i][V-1]}}, vd[i]};
				end
				CAP_V2: begin
					b_q[i]   <= {vd[i][V-1], vd[i]} - {v0_q[i][V-1], v0_q[i]};
					sum_q[i] <= sum_q[i] + {{(S-V){vd[i][V-1]}}, vd[i]};
				end
				CAP_V3: begin
					sum_q[i] <= sum_q[i] + {{(S-V){vd[i][V-1]}}, vd[i]}
						- {{(S-V-2){pt_q[i][V-1]}}, pt_q[i], 2'b00};
				end
				default: begin
				end
			endcase
		end
		case (cmd.act)
			ACT_NX_SET:  n_q[0] <= p_q[N-1:0];
			ACT_NX_SUB:  n_q[0] <= n_q[0] - p_q[N-1:0];
			ACT_NY_SET:  n_q[1] <= p_q[N-1:0];
			ACT_NY_SUB:  n_q[1] <= n_q[1] - p_q[N-1:0];
			ACT_NZ_SET:  n_q[2] <= p_q[N-1:0];
			ACT_NZ_SUB:  n_q[2] <= n_q[2] - p_q[N-1:0];
			ACT_ACC_SET: acc_q  <= pe;
			ACT_ACC_LO:  acc_q  <= acc_q + pe;
			ACT_ACC_HI:  acc_q  <= acc_q + (pe <<< K);
			default: begin
			end
		endcase
	end

	assign inside_res = inside_q;
endmodule

// ----- design/point_in_hexahedron_test_top.sv -----
// Point-in-hexahedron test: top level joining the sequencer and the datapath.
// Depends on pih_pkg, pih_ctrl, pih_dp.
//
// Input channel (in_valid/in_stall): op 0 writes one corner (vertex_index, coords),
// op 1 tests the point given by the coords against the stored cell.
// Output channel (out_valid/out_stall): one item per test, inside_res is 1 when the
// point is on or inside all six faces.
// A corner load yields no item; the next item may follow at once.
// A test works through six faces of 19 steps after its accept (four
// corner reads from the corner RAM's single read port, six cross-product and six dot-product
// multiplies on one shared multiplier), then the result is shown from the next cycle.
// The input is stalled from the accept of a test until its result is taken.
// While the receiver stalls, out_valid and inside_res hold.
// Reset clears the corner store through per-corner valid bits: unwritten corners
// read as zero. Reset also returns the sequencer to idle.
module point_in_hexahedron_test_top import pih_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [2:0]                   vertex_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         inside_res
);
	cmd_t cmd;

	pih_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	pih_dp #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.inside_res   (inside_res)
	);
endmodule
